// ----- sv/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and types of the bitmap-tree buddy allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int POOL_LOG2      = 11;
  localparam int MIN_BLOCK_LOG2 = 2;
  localparam int HEADER_BYTES   = 8;

  localparam int DEEPEST    = POOL_LOG2 - MIN_BLOCK_LOG2;
  localparam int POOL_BYTES = 1 << POOL_LOG2;

  // tree nodes use 1-based heap numbering: level L spans [2^L, 2^(L+1))
  localparam int NODE_W     = DEEPEST + 1;
  localparam int BIT_W      = 5;
  localparam int WORD_BITS  = 1 << BIT_W;
  localparam int WORD_AW    = NODE_W - BIT_W;
  localparam int TREE_WORDS = 1 << WORD_AW;

  localparam int LVL_W   = $clog2(POOL_LOG2 + 1);
  localparam int OFF_W   = POOL_LOG2;
  localparam int SLOT_AW = DEEPEST;
  localparam int SLOTS   = 1 << SLOT_AW;
  localparam int REQ_W   = 12;
  localparam int TOT_W   = REQ_W + 1;
  localparam int ST_W    = 2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [ST_W-1:0] ST_NO_FREE   = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] lo;
    logic [NODE_W-1:0] hi;
  } node_range_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] mask;
    logic                 found;
    logic [BIT_W-1:0]     idx;
  } word_res_t;

endpackage

// ----- sv/buddy_allocator_bitmap_tree.sv -----
// ----------------------------------------------------------------------------
// buddy_allocator_bitmap_tree
// Binary buddy allocator over a 2 KiB pool, node bitmap kept in a RAM.
// ----------------------------------------------------------------------------
// After reset the block clears its 32-word node bitmap, and only then takes
// its first item. One item is handled at a time; every bitmap word it touches
// goes through the single 32-bit read-modify-write path, and that path sets
// the rate. An allocate of a level-L block reads up to
// max(1, 2^(L-5)) words of level L, rewrites the words under the block at each
// deeper level and one word per ancestor; a free adds a level lookup and one
// word read. A finished result waits in S_DONE while the previous result is
// still held by out_stall. A new item is taken while the previous result
// still waits in the output register.
module buddy_allocator_bitmap_tree (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [bba_pkg::REQ_W-1:0]   in_req_size,
  input  logic [bba_pkg::OFF_W-1:0]   in_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bba_pkg::ST_W-1:0]    out_status,
  output logic [bba_pkg::OFF_W-1:0]   out_result_address
);

  localparam int NW  = bba_pkg::NODE_W;
  localparam int BW  = bba_pkg::BIT_W;
  localparam int WB  = bba_pkg::WORD_BITS;
  localparam int WA  = bba_pkg::WORD_AW;
  localparam int LW  = bba_pkg::LVL_W;
  localparam int OW  = bba_pkg::OFF_W;
  localparam int TW  = bba_pkg::TOT_W;
  localparam int SW  = bba_pkg::ST_W;
  localparam int XW  = OW + NW;

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_LVL      = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CHK = 4'd4;
  localparam logic [3:0] S_MARK_RD  = 4'd5;
  localparam logic [3:0] S_MARK_WR  = 4'd6;
  localparam logic [3:0] S_SIB_RD   = 4'd7;
  localparam logic [3:0] S_SIB_CHK  = 4'd8;
  localparam logic [3:0] S_ANC_RD   = 4'd9;
  localparam logic [3:0] S_ANC_WR   = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  logic [3:0]    state_r, state_nxt;
  logic [WA-1:0] clr_r, clr_nxt;
  logic          act_r, act_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [LW-1:0] d_r, d_nxt;
  logic [NW-1:0] h_r, h_nxt;
  logic [NW-1:0] lo_r, lo_nxt;
  logic [NW-1:0] hi_r, hi_nxt;
  logic [WA-1:0] w_r, w_nxt;
  logic          anc_r, anc_nxt;
  logic          cur_val_r, cur_val_nxt;
  logic          sib_r, sib_nxt;
  logic [SW-1:0] status_r, status_nxt;
  logic [OW-1:0] res_r, res_nxt;
  logic [OW-1:0] off_r, off_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_status_r, out_status_nxt;
  logic [OW-1:0] out_addr_r, out_addr_nxt;

  logic                 accept;
  logic [TW-1:0]        total_c;
  logic [LW-1:0]        alloc_lvl_c;
  logic [NW-1:0]        lvl_lo_c;
  logic [OW-1:0]        free_off_c;
  logic [LW-1:0]        lvl_rdata;
  logic [LW-1:0]        lvl_clip;
  logic [LW-1:0]        free_sh;
  logic [NW-1:0]        free_node_c;
  logic [NW-1:0]        found_node;
  logic [LW-1:0]        alloc_sh;
  logic [XW-1:0]        alloc_wide;
  logic [OW-1:0]        alloc_off_c;
  logic [NW-1:0]        lo_sh, hi_sh, par;
  logic [BW-1:0]        pb;
  logic                 anc_clr;

  logic                 tree_we;
  logic [WA-1:0]        tree_waddr;
  logic [WB-1:0]        tree_wdata;
  logic [WB-1:0]        tree_rdata;
  logic                 lvl_we;

  bba_pkg::node_range_t rng;
  bba_pkg::word_res_t   wres;

  assign in_stall           = (state_r != S_IDLE);
  assign accept             = in_valid && !in_stall;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;

  assign rng.lo = lo_r;
  assign rng.hi = hi_r;

  bba_word_unit u_word (
    .word_addr (w_r),
    .word_data (tree_rdata),
    .rng       (rng),
    .res       (wres)
  );

  bba_ram #(
    .WIDTH (bba_pkg::WORD_BITS),
    .DEPTH (bba_pkg::TREE_WORDS)
  ) u_tree_ram (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (w_r),
    .rdata (tree_rdata)
  );

  assign lvl_we = (state_r == S_DONE) && (act_r == bba_pkg::ACT_ALLOC) &&
                  (status_r == bba_pkg::ST_OK);

  bba_ram #(
    .WIDTH (bba_pkg::LVL_W),
    .DEPTH (bba_pkg::SLOTS)
  ) u_lvl_ram (
    .clk   (clk),
    .we    (lvl_we),
    .waddr (off_r[OW-1:bba_pkg::MIN_BLOCK_LOG2]),
    .wdata (lvl_r),
    .raddr (free_off_c[OW-1:bba_pkg::MIN_BLOCK_LOG2]),
    .rdata (lvl_rdata)
  );

  // request size to tree level: deepest level whose block still holds the sum
  always_comb begin
    total_c     = TW'(in_req_size) + TW'(bba_pkg::HEADER_BYTES);
    alloc_lvl_c = '0;
    for (int i = 0; i <= bba_pkg::DEEPEST; i++) begin
      if (total_c <= (TW'(1) << (bba_pkg::POOL_LOG2 - i))) begin
        alloc_lvl_c = LW'(i);
      end
    end
  end

  assign lvl_lo_c    = NW'(1) << alloc_lvl_c;
  assign free_off_c  = in_address - OW'(bba_pkg::HEADER_BYTES);
  assign lvl_clip    = (lvl_rdata > LW'(bba_pkg::DEEPEST)) ? LW'(bba_pkg::DEEPEST) : lvl_rdata;
  assign free_sh     = LW'(bba_pkg::POOL_LOG2) - lvl_clip;
  assign free_node_c = (NW'(1) << lvl_clip) + NW'(off_r >> free_sh);
  assign found_node  = {w_r, wres.idx};
  assign alloc_sh    = LW'(bba_pkg::POOL_LOG2) - lvl_r;
  assign alloc_wide  = XW'(found_node) << alloc_sh;
  assign alloc_off_c = alloc_wide[OW-1:0];
  assign lo_sh       = {lo_r[NW-2:0], 1'b0};
  assign hi_sh       = {hi_r[NW-2:0], 1'b1};
  assign par         = {1'b0, lo_r[NW-1:1]};
  assign pb          = par[BW-1:0];
  assign anc_clr     = !cur_val_r && !sib_r;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    act_nxt        = act_r;
    lvl_nxt        = lvl_r;
    d_nxt          = d_r;
    h_nxt          = h_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    w_nxt          = w_r;
    anc_nxt        = anc_r;
    cur_val_nxt    = cur_val_r;
    sib_nxt        = sib_r;
    status_nxt     = status_r;
    res_nxt        = res_r;
    off_nxt        = off_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    tree_we        = 1'b0;
    tree_waddr     = w_r;
    tree_wdata     = tree_rdata;

    case (state_r)
      S_CLR: begin
        tree_we    = 1'b1;
        tree_waddr = clr_r;
        tree_wdata = '0;
        clr_nxt    = clr_r + WA'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          act_nxt    = in_action;
          status_nxt = bba_pkg::ST_OK;
          res_nxt    = '0;
          if (in_action == bba_pkg::ACT_FREE) begin
            off_nxt   = free_off_c;
            state_nxt = S_LVL;
          end else if (total_c > TW'(bba_pkg::POOL_BYTES)) begin
            status_nxt = bba_pkg::ST_TOO_LARGE;
            state_nxt  = S_DONE;
          end else begin
            lvl_nxt   = alloc_lvl_c;
            lo_nxt    = lvl_lo_c;
            hi_nxt    = lvl_lo_c | (lvl_lo_c - NW'(1));
            w_nxt     = lvl_lo_c[NW-1:BW];
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_LVL: begin
        lvl_nxt   = lvl_clip;
        d_nxt     = lvl_clip;
        h_nxt     = free_node_c;
        lo_nxt    = free_node_c;
        hi_nxt    = free_node_c;
        w_nxt     = free_node_c[NW-1:BW];
        anc_nxt   = 1'b0;
        state_nxt = S_MARK_RD;
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (wres.found) begin
          h_nxt     = found_node;
          lo_nxt    = found_node;
          hi_nxt    = found_node;
          d_nxt     = lvl_r;
          anc_nxt   = 1'b0;
          off_nxt   = alloc_off_c;
          res_nxt   = alloc_off_c + OW'(bba_pkg::HEADER_BYTES);
          state_nxt = S_MARK_RD;
        end else if (w_r == hi_r[NW-1:BW]) begin
          status_nxt = bba_pkg::ST_NO_FREE;
          state_nxt  = S_DONE;
        end else begin
          w_nxt     = w_r + WA'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_MARK_RD: begin
        state_nxt = S_MARK_WR;
      end
      S_MARK_WR: begin
        tree_we    = 1'b1;
        tree_wdata = (act_r == bba_pkg::ACT_FREE) ? (tree_rdata & ~wres.mask)
                                                  : (tree_rdata | wres.mask);
        state_nxt  = S_MARK_RD;
        if (w_r != hi_r[NW-1:BW]) begin
          w_nxt = w_r + WA'(1);
        end else if (!anc_r) begin
          if (d_r != LW'(bba_pkg::DEEPEST)) begin
            d_nxt  = d_r + LW'(1);
            lo_nxt = lo_sh;
            hi_nxt = hi_sh;
            w_nxt  = lo_sh[NW-1:BW];
          end else if (lvl_r == '0) begin
            state_nxt = S_DONE;
          end else if (act_r == bba_pkg::ACT_ALLOC) begin
            anc_nxt = 1'b1;
            d_nxt   = lvl_r - LW'(1);
            lo_nxt  = {1'b0, h_r[NW-1:1]};
            hi_nxt  = {1'b0, h_r[NW-1:1]};
            w_nxt   = h_r[NW-1:BW+1];
          end else begin
            lo_nxt    = h_r;
            w_nxt     = h_r[NW-1:BW];
            state_nxt = S_SIB_RD;
          end
        end else if (d_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          d_nxt  = d_r - LW'(1);
          lo_nxt = par;
          hi_nxt = par;
          w_nxt  = par[NW-1:BW];
        end
      end
      S_SIB_RD: begin
        state_nxt = S_SIB_CHK;
      end
      S_SIB_CHK: begin
        sib_nxt     = tree_rdata[lo_r[BW-1:0] ^ BW'(1)];
        cur_val_nxt = 1'b0;
        w_nxt       = par[NW-1:BW];
        state_nxt   = S_ANC_RD;
      end
      S_ANC_RD: begin
        state_nxt = S_ANC_WR;
      end
      S_ANC_WR: begin
        // parent clears only when both children are free
        tree_we     = 1'b1;
        tree_wdata  = tree_rdata & ~(anc_clr ? (WB'(1) << pb) : '0);
        cur_val_nxt = anc_clr ? 1'b0 : tree_rdata[pb];
        sib_nxt     = tree_rdata[pb ^ BW'(1)];
        lo_nxt      = par;
        w_nxt       = par[NW-1:BW+1];
        state_nxt   = (par == NW'(1)) ? S_DONE : S_ANC_RD;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_addr_nxt   = res_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    lvl_r        <= lvl_nxt;
    d_r          <= d_nxt;
    h_r          <= h_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    w_r          <= w_nxt;
    anc_r        <= anc_nxt;
    cur_val_r    <= cur_val_nxt;
    sib_r        <= sib_nxt;
    status_r     <= status_nxt;
    res_r        <= res_nxt;
    off_r        <= off_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
  end

endmodule

// ----- sv/bba_ram.sv -----
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/bba_word_unit.sv -----
// ----------------------------------------------------------------------------
// bba_word_unit
// Shared compare unit for one bitmap word: node-range mask and first free
// node inside the range.
// ----------------------------------------------------------------------------
module bba_word_unit (
  input  logic [bba_pkg::WORD_AW-1:0]   word_addr,
  input  logic [bba_pkg::WORD_BITS-1:0] word_data,
  input  bba_pkg::node_range_t          rng,
  output bba_pkg::word_res_t            res
);

  localparam int WB = bba_pkg::WORD_BITS;
  localparam int BW = bba_pkg::BIT_W;

  logic [WB-1:0] in_rng;

  always_comb begin
    in_rng    = '0;
    res.found = 1'b0;
    res.idx   = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      in_rng[i] = ({word_addr, BW'(i)} >= rng.lo) && ({word_addr, BW'(i)} <= rng.hi);
      if (in_rng[i] && !word_data[i]) begin
        res.found = 1'b1;
        res.idx   = BW'(i);
      end
    end
    res.mask = in_rng;
  end

endmodule

// ----- sv/bba_checker.sv -----
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the buddy allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bba_pkg::ST_W-1:0]    out_status,
  input logic [bba_pkg::OFF_W-1:0]   out_result_address
);

  localparam int OW = bba_pkg::OFF_W;
  localparam logic [OW-1:0] ALIGN_MASK = OW'((1 << bba_pkg::MIN_BLOCK_LOG2) - 1);
  localparam logic [OW-1:0] HDR        = OW'(bba_pkg::HEADER_BYTES);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_result_address))
    else $error("stalled result item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an item");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != bba_pkg::ST_OK) |-> out_result_address == '0)
    else $error("failed request returned an address");

  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == bba_pkg::ST_OK) && (out_result_address != '0)
      |-> ((out_result_address - HDR) & ALIGN_MASK) == '0)
    else $error("allocated block not aligned to smallest block size");

endmodule

bind buddy_allocator_bitmap_tree bba_checker u_bba_checker (.*);

// ----- tb/sv/tb_buddy_allocator_bitmap_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_buddy_allocator_bitmap_tree
// Self-checking bench for the bitmap-tree buddy allocator. A clocked driver
// sends allocate and free requests from a queue. Each accepted item is run
// through a cycle-free model of the node bitmap and level table, and the
// outcome is queued. A clocked monitor compares every returned item with the
// oldest queued outcome. The stimulus is a directed opening, then random
// churn, a stretch with no idling, a tiny-block fill and free-heavy
// traffic. Both handshakes idle or stall at random.
// ----------------------------------------------------------------------------
module tb_buddy_allocator_bitmap_tree;

  localparam int POOL_LOG2      = bba_pkg::POOL_LOG2;
  localparam int MIN_BLOCK_LOG2 = bba_pkg::MIN_BLOCK_LOG2;
  localparam int HEADER_BYTES   = bba_pkg::HEADER_BYTES;
  localparam int DEEPEST        = bba_pkg::DEEPEST;
  localparam int POOL_BYTES     = bba_pkg::POOL_BYTES;
  localparam int SLOTS          = bba_pkg::SLOTS;
  localparam int REQ_W          = bba_pkg::REQ_W;
  localparam int OFF_W          = bba_pkg::OFF_W;
  localparam int ST_W           = bba_pkg::ST_W;

  localparam logic [ST_W-1:0] ST_OK        = bba_pkg::ST_OK;
  localparam logic [ST_W-1:0] ST_TOO_LARGE = bba_pkg::ST_TOO_LARGE;
  localparam logic [ST_W-1:0] ST_NO_FREE   = bba_pkg::ST_NO_FREE;
  localparam logic            ACT_ALLOC    = bba_pkg::ACT_ALLOC;
  localparam logic            ACT_FREE     = bba_pkg::ACT_FREE;

  localparam int NODES      = (1 << (DEEPEST + 1)) - 1;
  localparam int RAND_ITEMS = 1700;
  localparam int HANG_LIMIT = 5000;

  typedef struct packed {
    logic             action;
    logic [REQ_W-1:0] req_size;
    logic [OFF_W-1:0] address;
  } request_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] addr;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_action = 1'b0;
  logic [REQ_W-1:0] in_req_size = '0;
  logic [OFF_W-1:0] in_address = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic [ST_W-1:0] out_status;
  logic [OFF_W-1:0] out_result_address;

  // shadow of the allocator
  bit node_busy [NODES];
  int slot_level [SLOTS];
  bit slot_seen [SLOTS];
  int touched_slots[$];
  logic [OFF_W-1:0] held_ptrs[$];

  request_t queued_items[$];
  outcome_t due_outcomes[$];
  bit calm = 1'b0;
  int errors = 0;
  int hang_cycles = 0;

  buddy_allocator_bitmap_tree u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_req_size       (in_req_size),
    .in_address        (in_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_result_address(out_result_address)
  );

  always #4 clk = ~clk;

  function automatic bit roll_idle();
    return !calm && ($urandom_range(0, 99) < 24);
  endfunction

  function automatic void paint_subtree(int node, int lvl, bit v);
    int d, j, span, first;
    for (d = lvl; d <= DEEPEST; d++) begin
      span = 1 << (d - lvl);
      first = (node + 1) * span - 1;
      for (j = 0; j < span; j++) begin
        if (first + j < NODES) node_busy[first + j] = v;
      end
    end
  endfunction

  function automatic outcome_t buddy_outcome(logic act, logic [REQ_W-1:0] req,
                                             logic [OFF_W-1:0] addr);
    outcome_t res;
    int total, pw, lvl, base, k, node, offs, slot;
    res.status = ST_OK;
    res.addr = '0;
    if (act == ACT_ALLOC) begin
      total = int'(req) + HEADER_BYTES;
      if (total > POOL_BYTES) begin
        res.status = ST_TOO_LARGE;
        return res;
      end
      pw = MIN_BLOCK_LOG2;
      while ((1 << pw) < total) pw++;
      lvl = POOL_LOG2 - pw;
      base = (1 << lvl) - 1;
      k = 0;
      while (k < (1 << lvl) && node_busy[base + k]) k++;
      if (k == (1 << lvl)) begin
        res.status = ST_NO_FREE;
        return res;
      end
      node = base + k;
      offs = k << pw;
      paint_subtree(node, lvl, 1'b1);
      while (node > 0) begin
        node = (node - 1) >> 1;
        node_busy[node] = 1'b1;
      end
      slot = offs >> MIN_BLOCK_LOG2;
      slot_level[slot] = lvl;
      if (!slot_seen[slot]) begin
        slot_seen[slot] = 1'b1;
        touched_slots.push_back(slot);
      end
      res.addr = OFF_W'(offs + HEADER_BYTES);
      held_ptrs.push_back(res.addr);
    end else begin
      // free is unchecked: wrap the offset and trust the stored level
      offs = (int'(addr) - HEADER_BYTES) & (POOL_BYTES - 1);
      lvl = slot_level[offs >> MIN_BLOCK_LOG2];
      if (lvl > DEEPEST) lvl = DEEPEST;
      node = (1 << lvl) - 1 + (offs >> (POOL_LOG2 - lvl));
      paint_subtree(node, lvl, 1'b0);
      while (node > 0) begin
        node = (node - 1) >> 1;
        if (!node_busy[2 * node + 1] && !node_busy[2 * node + 2]) node_busy[node] = 1'b0;
      end
      for (k = 0; k < held_ptrs.size(); k++) begin
        if (held_ptrs[k] == addr) begin
          held_ptrs.delete(k);
          break;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin : drive_items
    request_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due_outcomes.push_back(buddy_outcome(in_action, in_req_size, in_address));
      end
      if (!in_valid || !in_stall) begin
        if (queued_items.size() != 0 && !roll_idle()) begin
          nxt = queued_items.pop_front();
          in_action <= nxt.action;
          in_req_size <= nxt.req_size;
          in_address <= nxt.address;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= roll_idle();
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, expected none, got status %0d addr %0d",
                 $time, out_status, out_result_address);
      end else begin
        want = due_outcomes.pop_front();
        if (out_status !== want.status) begin
          errors++;
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_status);
        end
        if (out_result_address !== want.addr) begin
          errors++;
          $display("%0t: result_address mismatch, expected %0d, got %0d",
                   $time, want.addr, out_result_address);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      hang_cycles <= 0;
    else
      hang_cycles <= hang_cycles + 1;
    if (hang_cycles >= HANG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // every item waits until the previous one is taken and modeled
  task automatic drain_input();
    while (queued_items.size() != 0 || in_valid) @(negedge clk);
  endtask

  task automatic issue(logic act, int req, int addr);
    drain_input();
    queued_items.push_back('{act, REQ_W'(req), OFF_W'(addr)});
  endtask

  task automatic release_all();
    drain_input();
    while (held_ptrs.size() != 0) begin
      issue(ACT_FREE, $urandom, held_ptrs[0]);
      drain_input();
    end
  endtask

  function automatic int pick_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 56);
    if (r < 80) return $urandom_range(0, 504);
    if (r < 95) return $urandom_range(0, 2040);
    return $urandom_range(0, 4095);
  endfunction

  initial begin : stimulus
    int i, r, slot;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    issue(ACT_ALLOC, 0, $urandom);
    drain_input();
    issue(ACT_FREE, 0, held_ptrs[$]);
    issue(ACT_ALLOC, 4095, $urandom);
    issue(ACT_ALLOC, POOL_BYTES - HEADER_BYTES + 1, $urandom);
    issue(ACT_ALLOC, POOL_BYTES - HEADER_BYTES, $urandom);
    issue(ACT_ALLOC, 0, $urandom);
    issue(ACT_ALLOC, POOL_BYTES - HEADER_BYTES, $urandom);
    drain_input();
    issue(ACT_FREE, 4095, held_ptrs[$]);
    issue(ACT_ALLOC, POOL_BYTES / 2 - HEADER_BYTES, 0);
    issue(ACT_ALLOC, POOL_BYTES / 2 - HEADER_BYTES, 2047);
    issue(ACT_ALLOC, 0, $urandom);
    drain_input();
    issue(ACT_FREE, $urandom, held_ptrs[0]);
    issue(ACT_ALLOC, 1, $urandom);
    issue(ACT_ALLOC, 24, $urandom);
    issue(ACT_ALLOC, 25, $urandom);
    issue(ACT_ALLOC, 2047, $urandom);
    drain_input();
    issue(ACT_FREE, $urandom, held_ptrs[$]);
    release_all();

    for (i = 0; i < RAND_ITEMS; i++) begin
      calm = (i >= 600 && i < 900);
      if (i == 1000) release_all();
      drain_input();
      r = $urandom_range(0, 99);
      if (i >= 1000 && i < 1300) begin
        // tiny-block fill with occasional frees
        if (r < 70 || held_ptrs.size() == 0) begin
          issue(ACT_ALLOC, (r < 60) ? 0 : $urandom_range(0, 8), $urandom);
        end else begin
          issue(ACT_FREE, $urandom, held_ptrs[$urandom_range(0, held_ptrs.size() - 1)]);
        end
      end else if (held_ptrs.size() == 0 || r < ((i >= 1300) ? 35 : 50)) begin
        issue(ACT_ALLOC, pick_req(), $urandom);
      end else if (r < 92) begin
        issue(ACT_FREE, $urandom, held_ptrs[$urandom_range(0, held_ptrs.size() - 1)]);
      end else begin
        // stray free inside a slot that some allocate has written
        slot = touched_slots[$urandom_range(0, touched_slots.size() - 1)];
        issue(ACT_FREE, $urandom,
              ((slot << MIN_BLOCK_LOG2) | $urandom_range(0, (1 << MIN_BLOCK_LOG2) - 1))
              + HEADER_BYTES);
      end
    end
    calm = 1'b0;

    drain_input();
    while (due_outcomes.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bba_word_unit.sv
sv/buddy_allocator_bitmap_tree.sv
sv/bba_checker.sv
tb/sv/tb_buddy_allocator_bitmap_tree.sv
